FILE: design/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg: shared types, constants and helpers
// Widths, register codes and small arithmetic helpers of the limited face
// reconstruction datapath.
// ----------------------------------------------------------------------------
package lfr_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int XW          = 40;   // face-level intermediates
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int METHOD_W    = 3;
   localparam int THRESH_W    = 16;

   // divide-by-three by reciprocal, exact after one correction
   localparam int DIV3_XW    = 34;
   localparam int DIV3_RW    = 33;
   localparam int DIV3_PW    = DIV3_XW + DIV3_RW;
   localparam int DIV3_SHIFT = 34;
   localparam logic [DIV3_RW-1:0] DIV3_RECIP = 33'h155555555;

   // curvature scaling divider
   localparam int QUO_W = 34;
   localparam int DEN_W = 40;
   localparam int LIM_W = 36;
   localparam int NUM_W = QUO_W + LIM_W;
   localparam int A_LO  = 17;
   localparam int L_LO  = 18;

   localparam int PRE_STAGES = 12;
   localparam int LATENCY    = PRE_STAGES + QUO_W + 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAT   = 2'd1;

   typedef enum logic [METHOD_W-1:0] {
      METHOD_UPWIND = 3'd0,
      METHOD_FROMM  = 3'd1,
      METHOD_MINMOD = 3'd2,
      METHOD_MC     = 3'd3,
      METHOD_PPM    = 3'd4
   } method_type;

   typedef logic signed [XW-1:0] wide_type;
   typedef logic [XW-1:0]        umag_type;

   typedef struct packed {
      logic     scale;
      logic     neg_l;
      logic     neg_r;
      wide_type centre;
      wide_type direct_l;
      wide_type direct_r;
   } side_type;

   function automatic umag_type mag_of(input wide_type x);
      return x[XW-1] ? umag_type'(-x) : umag_type'(x);
   endfunction

   function automatic umag_type mag5(input wide_type x);
      umag_type u;
      u = mag_of(x);
      return (u << 2) + u;
   endfunction

   function automatic wide_type apply_sign(input logic neg, input umag_type u);
      return neg ? -wide_type'(u) : wide_type'(u);
   endfunction

   function automatic logic same_sign(input wide_type a, input wide_type b);
      return ((!a[XW-1] && (a != '0)) && (!b[XW-1] && (b != '0))) || (a[XW-1] && b[XW-1]);
   endfunction

   function automatic umag_type umin(input umag_type a, input umag_type b);
      return (a < b) ? a : b;
   endfunction

   // round n / 2^k to nearest, ties away from zero
   function automatic wide_type rdiv_shift(input wide_type n, input int k);
      umag_type u;
      u = (mag_of(n) + (umag_type'(1) << (k - 1))) >> k;
      return apply_sign(n[XW-1], u);
   endfunction

   // floor(x / 3) from the reciprocal product
   function automatic logic [DIV3_RW-1:0] div3_fix(input logic [DIV3_XW-1:0] x,
                                                   input logic [DIV3_PW-1:0] prod);
      logic [DIV3_RW-1:0] q0;
      logic [DIV3_XW+1:0] r;
      q0 = prod[DIV3_PW-1:DIV3_SHIFT];
      r  = {2'b00, x} - ({3'b000, q0} + {2'b00, q0, 1'b0});
      return (r >= (DIV3_XW+2)'(3)) ? q0 + DIV3_RW'(1) : q0;
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] sat_value(input wide_type x);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (VALUE_WIDTH - 1)) - wide_type'(1);
      lo = -hi - wide_type'(1);
      if (x > hi) begin
         return hi[VALUE_WIDTH-1:0];
      end else if (x < lo) begin
         return lo[VALUE_WIDTH-1:0];
      end
      return x[VALUE_WIDTH-1:0];
   endfunction

endpackage

FILE: design/lfr_div.sv
// ----------------------------------------------------------------------------
// lfr_div: pipelined restoring divider for curvature scaling
// Divides both face numerators by a shared denominator, one quotient bit per
// stage, and rounds the quotient to nearest with ties up.
// ----------------------------------------------------------------------------
module lfr_div import lfr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num_l,
   input  logic [NUM_W-1:0]   in_num_r,
   input  logic [DEN_W-1:0]   in_den,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [QUO_W-1:0]   out_quo_l,
   output logic [QUO_W-1:0]   out_quo_r,
   output side_type           out_side
);

   logic               vld_ff   [QUO_W];
   logic [DEN_W-1:0]   rem_l_ff [QUO_W];
   logic [DEN_W-1:0]   rem_r_ff [QUO_W];
   logic [QUO_W-1:0]   nq_l_ff  [QUO_W];
   logic [QUO_W-1:0]   nq_r_ff  [QUO_W];
   logic [DEN_W-1:0]   den_ff   [QUO_W];
   side_type           side_ff  [QUO_W];

   // shift in one numerator bit, trial subtract, shift out one quotient bit
   function automatic logic [DEN_W+QUO_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                       input logic [QUO_W-1:0] nq,
                                                       input logic [DEN_W-1:0] den);
      logic [DEN_W:0]   sh;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] nr;
      sh   = {rem, nq[QUO_W-1]};
      diff = sh - {1'b0, den};
      ge   = (sh >= {1'b0, den});
      nr   = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      return {nr, nq[QUO_W-2:0], ge};
   endfunction

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic                     vld_prev;
      logic [DEN_W-1:0]         rem_l_prev;
      logic [DEN_W-1:0]         rem_r_prev;
      logic [QUO_W-1:0]         nq_l_prev;
      logic [QUO_W-1:0]         nq_r_prev;
      logic [DEN_W-1:0]         den_prev;
      side_type                 side_prev;
      logic [DEN_W+QUO_W-1:0]   step_l_in;
      logic [DEN_W+QUO_W-1:0]   step_r_in;

      if (i == 0) begin : g_first
         assign vld_prev   = in_valid;
         assign rem_l_prev = DEN_W'(in_num_l[NUM_W-1:QUO_W]);
         assign rem_r_prev = DEN_W'(in_num_r[NUM_W-1:QUO_W]);
         assign nq_l_prev  = in_num_l[QUO_W-1:0];
         assign nq_r_prev  = in_num_r[QUO_W-1:0];
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_rest
         assign vld_prev   = vld_ff[i-1];
         assign rem_l_prev = rem_l_ff[i-1];
         assign rem_r_prev = rem_r_ff[i-1];
         assign nq_l_prev  = nq_l_ff[i-1];
         assign nq_r_prev  = nq_r_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      assign step_l_in = div_step(rem_l_prev, nq_l_prev, den_prev);
      assign step_r_in = div_step(rem_r_prev, nq_r_prev, den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_l_ff[i] <= step_l_in[DEN_W+QUO_W-1:QUO_W];
         rem_r_ff[i] <= step_r_in[DEN_W+QUO_W-1:QUO_W];
         nq_l_ff[i]  <= step_l_in[QUO_W-1:0];
         nq_r_ff[i]  <= step_r_in[QUO_W-1:0];
         den_ff[i]   <= den_prev;
         side_ff[i]  <= side_prev;
      end
   end

   // round up when twice the remainder reaches the divisor
   logic rnd_l;
   logic rnd_r;
   assign rnd_l = ({rem_l_ff[QUO_W-1], 1'b0} >= {1'b0, den_ff[QUO_W-1]});
   assign rnd_r = ({rem_r_ff[QUO_W-1], 1'b0} >= {1'b0, den_ff[QUO_W-1]});

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo_l = nq_l_ff[QUO_W-1] + QUO_W'(rnd_l);
   assign out_quo_r = nq_r_ff[QUO_W-1] + QUO_W'(rnd_r);
   assign out_side  = side_ff[QUO_W-1];

endmodule

FILE: design/limited_face_reconstruction_core.sv
// ----------------------------------------------------------------------------
// limited_face_reconstruction_core: limited left/right face reconstruction
// Five cell values in, two saturated face values out; upwind, Fromm, minmod,
// monotonized central or PPM with curvature limiting, picked by register.
//
//   channel   ports                         direction  timing
//   request   start / busy, req_*           in         one word per cycle
//   response  rsp_valid, rsp_*              out        strobe, one cycle
//   csr       csr_valid / csr_ready, index  in         ready always high
//
// One word enters every cycle; each result passes through 12 front stages,
// the 34-stage quotient pipeline and the output register.
// busy stays low. Synchronous reset clears the valid bits and sets
// method_select to monotonized central and flat_threshold to zero.
// ----------------------------------------------------------------------------
module limited_face_reconstruction_core import lfr_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [VALUE_WIDTH-1:0]  req_far_left_value,
   input  logic signed [VALUE_WIDTH-1:0]  req_left_value,
   input  logic signed [VALUE_WIDTH-1:0]  req_centre_value,
   input  logic signed [VALUE_WIDTH-1:0]  req_right_value,
   input  logic signed [VALUE_WIDTH-1:0]  req_far_right_value,
   output logic                           rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]  rsp_left_face,
   output logic signed [VALUE_WIDTH-1:0]  rsp_right_face,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data
);

   typedef struct packed {
      logic     ppm;
      wide_type m;
      wide_type c;
      wide_type p;
      wide_type dlo;
      wide_type dc;
      wide_type dhi;
      wide_type sl;
      wide_type sr;
   } carry_type;

   typedef struct packed {
      logic     keep;
      wide_type f;
      logic     agree;
      logic     d2neg;
      umag_type m5l;
      umag_type m5r;
      umag_type m4;
      wide_type base;
   } face_a_type;

   typedef struct packed {
      logic                keep;
      wide_type            f;
      logic                neg;
      logic [DIV3_XW-1:0]  x;
   } face_b_type;

   function automatic face_a_type face_test(input wide_type f, input wide_type a,
                                            input wide_type b, input wide_type d2l,
                                            input wide_type d2r);
      face_a_type o;
      wide_type   t;
      wide_type   d2;
      wide_type   s;
      t       = a - (f <<< 1) + b;
      d2      = (t <<< 1) + t;
      s       = a + b;
      o.keep  = !same_sign(a - f, b - f);
      o.f     = f;
      o.agree = same_sign(d2, d2l) && same_sign(d2, d2r);
      o.d2neg = d2[XW-1];
      o.m5l   = mag5(d2l);
      o.m5r   = mag5(d2r);
      o.m4    = mag_of(d2) << 2;
      o.base  = (s <<< 3) + (s <<< 2);
      return o;
   endfunction

   function automatic face_b_type face_limit(input face_a_type a);
      face_b_type o;
      umag_type   lim;
      wide_type   n;
      umag_type   u;
      lim    = a.agree ? umin(a.m5l, umin(a.m5r, a.m4)) : '0;
      n      = a.base - apply_sign(a.d2neg, lim);
      u      = (mag_of(n) + umag_type'(12)) >> 3;
      o.keep = a.keep;
      o.f    = a.f;
      o.neg  = n[XW-1];
      o.x    = u[DIV3_XW-1:0];
      return o;
   endfunction

   // ---------------- configuration ----------------
   logic [METHOD_W-1:0] method_ff, method_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      method_in = method_ff;
      thresh_in = thresh_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_METHOD: method_in = csr_data[METHOD_W-1:0];
            CSR_FLAT:   thresh_in = csr_data[THRESH_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METHOD_MC;
         thresh_ff <= '0;
      end else begin
         method_ff <= method_in;
         thresh_ff <= thresh_in;
      end
   end

   // ---------------- valid chain ----------------
   logic [PRE_STAGES-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[PRE_STAGES-2:0], start && !busy};

   // ---------------- stage registers ----------------
   wide_type mm0_ff, m0_ff, c0_ff, p0_ff, pp0_ff;

   carry_type           carry1_ff, carry1_in;
   logic                nr_neg1_ff, nl_neg1_ff, nr_neg1_in, nl_neg1_in;
   logic [DIV3_XW-1:0]  nr_x1_ff, nl_x1_ff, nr_x1_in, nl_x1_in;

   carry_type           carry2_ff;
   logic                nr_neg2_ff, nl_neg2_ff;
   logic [DIV3_XW-1:0]  nr_x2_ff, nl_x2_ff;
   logic [DIV3_PW-1:0]  prod_r2_ff, prod_l2_ff;

   carry_type           carry3_ff;
   wide_type            r3_ff, l3_ff, r3_in, l3_in;

   carry_type           carry4_ff;
   face_a_type          fa_r4_ff, fa_l4_ff;

   carry_type           carry5_ff;
   face_b_type          fb_r5_ff, fb_l5_ff;

   carry_type           carry6_ff;
   face_b_type          fb_r6_ff, fb_l6_ff;
   logic [DIV3_PW-1:0]  prod_r6_ff, prod_l6_ff;

   carry_type           carry7_ff;
   wide_type            r7_ff, l7_ff, r7_in, l7_in;

   carry_type           carry8_ff;
   wide_type            r8_ff, l8_ff;
   logic                ext8_ff, flat8_ff, negr8_ff, negl8_ff;
   logic                ext8_in, flat8_in;
   umag_type            m5lo8_ff, m5c8_ff, m5hi8_ff, m48_ff, m48_in;
   logic [QUO_W-1:0]    ar8_ff, al8_ff, ar8_in, al8_in;
   wide_type            dr8_in, dl8_in, d2_8_in, t8_in;
   umag_type            mr8_in, ml8_in;

   side_type            side9_ff, side9_in;
   logic [QUO_W-1:0]    ar9_ff, al9_ff;
   logic [LIM_W-1:0]    lim9_ff, lim9_in;
   logic [DEN_W-1:0]    den9_ff;
   umag_type            lim9_full;

   side_type            side10_ff;
   logic [DEN_W-1:0]    den10_ff;
   logic [A_LO+L_LO-1:0] pll_r10_ff, plh_r10_ff, phl_r10_ff, phh_r10_ff;
   logic [A_LO+L_LO-1:0] pll_l10_ff, plh_l10_ff, phl_l10_ff, phh_l10_ff;

   side_type            side11_ff;
   logic [DEN_W-1:0]    den11_ff;
   logic [NUM_W-1:0]    num_r11_ff, num_l11_ff, num_r11_in, num_l11_in;

   // ---------------- stage 1: simple slopes and PPM face sums ----------------
   wide_type d_pm, d_pc, d_cm, x_pc4, x_cm4, mm2, mc3, h_sel, sum_r, sum_l, n_r, n_l;
   umag_type u_r, u_l;

   always_comb begin
      d_pm  = p0_ff - m0_ff;
      d_pc  = p0_ff - c0_ff;
      d_cm  = c0_ff - m0_ff;
      x_pc4 = d_pc <<< 2;
      x_cm4 = d_cm <<< 2;
      mm2   = '0;
      if (same_sign(d_pc, d_cm)) begin
         mm2 = (mag_of(d_pc) < mag_of(d_cm)) ? d_pc : d_cm;
      end
      mc3 = '0;
      if (same_sign(x_pc4, d_pm) && same_sign(x_pc4, x_cm4)) begin
         mc3 = apply_sign(x_pc4[XW-1],
                          umin(mag_of(x_pc4), umin(mag_of(d_pm), mag_of(x_cm4))));
      end
      unique case (method_ff)
         METHOD_FROMM:  h_sel = rdiv_shift(d_pm, 2);
         METHOD_MINMOD: h_sel = rdiv_shift(mm2, 1);
         METHOD_MC:     h_sel = rdiv_shift(mc3, 2);
         default:       h_sel = '0;
      endcase

      sum_r = c0_ff + p0_ff;
      sum_l = c0_ff + m0_ff;
      n_r   = (sum_r <<< 3) - sum_r - (m0_ff + pp0_ff);
      n_l   = (sum_l <<< 3) - sum_l - (mm0_ff + p0_ff);
      u_r   = (mag_of(n_r) + umag_type'(6)) >> 2;
      u_l   = (mag_of(n_l) + umag_type'(6)) >> 2;

      carry1_in.ppm = (method_ff == METHOD_PPM);
      carry1_in.m   = m0_ff;
      carry1_in.c   = c0_ff;
      carry1_in.p   = p0_ff;
      carry1_in.dlo = mm0_ff - (m0_ff <<< 1) + c0_ff;
      carry1_in.dc  = m0_ff - (c0_ff <<< 1) + p0_ff;
      carry1_in.dhi = c0_ff - (p0_ff <<< 1) + pp0_ff;
      carry1_in.sl  = c0_ff - h_sel;
      carry1_in.sr  = c0_ff + h_sel;
      nr_neg1_in    = n_r[XW-1];
      nl_neg1_in    = n_l[XW-1];
      nr_x1_in      = u_r[DIV3_XW-1:0];
      nl_x1_in      = u_l[DIV3_XW-1:0];
   end

   // ---------------- stage 3: PPM first-guess faces ----------------
   assign r3_in = apply_sign(nr_neg2_ff, umag_type'(div3_fix(nr_x2_ff, prod_r2_ff)));
   assign l3_in = apply_sign(nl_neg2_ff, umag_type'(div3_fix(nl_x2_ff, prod_l2_ff)));

   // ---------------- stage 7: limited faces ----------------
   assign r7_in = fb_r6_ff.keep ? fb_r6_ff.f :
                  apply_sign(fb_r6_ff.neg, umag_type'(div3_fix(fb_r6_ff.x, prod_r6_ff)));
   assign l7_in = fb_l6_ff.keep ? fb_l6_ff.f :
                  apply_sign(fb_l6_ff.neg, umag_type'(div3_fix(fb_l6_ff.x, prod_l6_ff)));

   // ---------------- stage 8: extremum test ----------------
   always_comb begin
      dr8_in   = r7_ff - carry7_ff.c;
      dl8_in   = l7_ff - carry7_ff.c;
      t8_in    = l7_ff - (carry7_ff.c <<< 1) + r7_ff;
      d2_8_in  = (t8_in <<< 2) + (t8_in <<< 1);
      ext8_in  = !same_sign(dr8_in, -dl8_in) ||
                 !same_sign(carry7_ff.m - carry7_ff.c, carry7_ff.c - carry7_ff.p);
      flat8_in = (mag_of(d2_8_in) < umag_type'(thresh_ff)) ||
                 !(same_sign(d2_8_in, carry7_ff.dc) && same_sign(d2_8_in, carry7_ff.dlo) &&
                   same_sign(d2_8_in, carry7_ff.dhi));
      m48_in   = mag_of(d2_8_in) << 2;
      mr8_in   = mag_of(dr8_in);
      ml8_in   = mag_of(dl8_in);
      ar8_in   = mr8_in[QUO_W-1:0];
      al8_in   = ml8_in[QUO_W-1:0];
   end

   // ---------------- stage 9: method decision ----------------
   always_comb begin
      lim9_full          = umin(umin(m5lo8_ff, m5hi8_ff), umin(m5c8_ff, m48_ff));
      lim9_in            = lim9_full[LIM_W-1:0];
      side9_in.scale     = 1'b0;
      side9_in.neg_l     = negl8_ff;
      side9_in.neg_r     = negr8_ff;
      side9_in.centre    = carry8_ff.c;
      side9_in.direct_l  = l8_ff;
      side9_in.direct_r  = r8_ff;
      priority if (!carry8_ff.ppm) begin
         side9_in.direct_l = carry8_ff.sl;
         side9_in.direct_r = carry8_ff.sr;
      end else if (!ext8_ff) begin
         side9_in.scale = 1'b0;
      end else if (flat8_ff) begin
         side9_in.direct_l = carry8_ff.c;
         side9_in.direct_r = carry8_ff.c;
      end else begin
         side9_in.scale = 1'b1;
      end
   end

   // ---------------- stage 11: partial product sum ----------------
   assign num_r11_in = (NUM_W'(phh_r10_ff) << (A_LO + L_LO)) + (NUM_W'(phl_r10_ff) << A_LO) +
                       (NUM_W'(plh_r10_ff) << L_LO) + NUM_W'(pll_r10_ff);
   assign num_l11_in = (NUM_W'(phh_l10_ff) << (A_LO + L_LO)) + (NUM_W'(phl_l10_ff) << A_LO) +
                       (NUM_W'(plh_l10_ff) << L_LO) + NUM_W'(pll_l10_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      // stage 0
      mm0_ff <= wide_type'(req_far_left_value);
      m0_ff  <= wide_type'(req_left_value);
      c0_ff  <= wide_type'(req_centre_value);
      p0_ff  <= wide_type'(req_right_value);
      pp0_ff <= wide_type'(req_far_right_value);
      // stage 1
      carry1_ff  <= carry1_in;
      nr_neg1_ff <= nr_neg1_in;
      nl_neg1_ff <= nl_neg1_in;
      nr_x1_ff   <= nr_x1_in;
      nl_x1_ff   <= nl_x1_in;
      // stage 2
      carry2_ff  <= carry1_ff;
      nr_neg2_ff <= nr_neg1_ff;
      nl_neg2_ff <= nl_neg1_ff;
      nr_x2_ff   <= nr_x1_ff;
      nl_x2_ff   <= nl_x1_ff;
      prod_r2_ff <= DIV3_PW'(nr_x1_ff) * DIV3_PW'(DIV3_RECIP);
      prod_l2_ff <= DIV3_PW'(nl_x1_ff) * DIV3_PW'(DIV3_RECIP);
      // stage 3
      carry3_ff <= carry2_ff;
      r3_ff     <= r3_in;
      l3_ff     <= l3_in;
      // stage 4
      carry4_ff <= carry3_ff;
      fa_r4_ff  <= face_test(r3_ff, carry3_ff.c, carry3_ff.p, carry3_ff.dc, carry3_ff.dhi);
      fa_l4_ff  <= face_test(l3_ff, carry3_ff.m, carry3_ff.c, carry3_ff.dlo, carry3_ff.dc);
      // stage 5
      carry5_ff <= carry4_ff;
      fb_r5_ff  <= face_limit(fa_r4_ff);
      fb_l5_ff  <= face_limit(fa_l4_ff);
      // stage 6
      carry6_ff  <= carry5_ff;
      fb_r6_ff   <= fb_r5_ff;
      fb_l6_ff   <= fb_l5_ff;
      prod_r6_ff <= DIV3_PW'(fb_r5_ff.x) * DIV3_PW'(DIV3_RECIP);
      prod_l6_ff <= DIV3_PW'(fb_l5_ff.x) * DIV3_PW'(DIV3_RECIP);
      // stage 7
      carry7_ff <= carry6_ff;
      r7_ff     <= r7_in;
      l7_ff     <= l7_in;
      // stage 8
      carry8_ff <= carry7_ff;
      r8_ff     <= r7_ff;
      l8_ff     <= l7_ff;
      ext8_ff   <= ext8_in;
      flat8_ff  <= flat8_in;
      negr8_ff  <= dr8_in[XW-1];
      negl8_ff  <= dl8_in[XW-1];
      m5lo8_ff  <= mag5(carry7_ff.dlo);
      m5c8_ff   <= mag5(carry7_ff.dc);
      m5hi8_ff  <= mag5(carry7_ff.dhi);
      m48_ff    <= m48_in;
      ar8_ff    <= ar8_in;
      al8_ff    <= al8_in;
      // stage 9
      side9_ff <= side9_in;
      ar9_ff   <= ar8_ff;
      al9_ff   <= al8_ff;
      lim9_ff  <= lim9_in;
      den9_ff  <= m48_ff[DEN_W-1:0];
      // stage 10: split multiply
      side10_ff  <= side9_ff;
      den10_ff   <= den9_ff;
      pll_r10_ff <= (A_LO+L_LO)'(ar9_ff[A_LO-1:0] * lim9_ff[L_LO-1:0]);
      plh_r10_ff <= (A_LO+L_LO)'(ar9_ff[A_LO-1:0] * lim9_ff[LIM_W-1:L_LO]);
      phl_r10_ff <= (A_LO+L_LO)'(ar9_ff[QUO_W-1:A_LO] * lim9_ff[L_LO-1:0]);
      phh_r10_ff <= (A_LO+L_LO)'(ar9_ff[QUO_W-1:A_LO] * lim9_ff[LIM_W-1:L_LO]);
      pll_l10_ff <= (A_LO+L_LO)'(al9_ff[A_LO-1:0] * lim9_ff[L_LO-1:0]);
      plh_l10_ff <= (A_LO+L_LO)'(al9_ff[A_LO-1:0] * lim9_ff[LIM_W-1:L_LO]);
      phl_l10_ff <= (A_LO+L_LO)'(al9_ff[QUO_W-1:A_LO] * lim9_ff[L_LO-1:0]);
      phh_l10_ff <= (A_LO+L_LO)'(al9_ff[QUO_W-1:A_LO] * lim9_ff[LIM_W-1:L_LO]);
      // stage 11
      side11_ff  <= side10_ff;
      den11_ff   <= den10_ff;
      num_r11_ff <= num_r11_in;
      num_l11_ff <= num_l11_in;
   end

   // ---------------- quotient pipeline ----------------
   logic             div_valid;
   logic [QUO_W-1:0] quo_l, quo_r;
   side_type         div_side;

   lfr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PRE_STAGES-1]),
      .in_num_l  (num_l11_ff),
      .in_num_r  (num_r11_ff),
      .in_den    (den11_ff),
      .in_side   (side11_ff),
      .out_valid (div_valid),
      .out_quo_l (quo_l),
      .out_quo_r (quo_r),
      .out_side  (div_side)
   );

   // ---------------- output register ----------------
   wide_type                       face_l, face_r;
   logic                           rsp_valid_ff;
   logic signed [VALUE_WIDTH-1:0]  left_ff, right_ff, left_in, right_in;

   always_comb begin
      face_l   = div_side.scale ?
                 div_side.centre + apply_sign(div_side.neg_l, umag_type'(quo_l)) :
                 div_side.direct_l;
      face_r   = div_side.scale ?
                 div_side.centre + apply_sign(div_side.neg_r, umag_type'(quo_r)) :
                 div_side.direct_r;
      left_in  = sat_value(face_l);
      right_in = sat_value(face_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_face  = left_ff;
   assign rsp_right_face = right_ff;

endmodule

FILE: design/lfr_check.sv
// ----------------------------------------------------------------------------
// lfr_check: port-level checks for the face reconstruction core
// Watches the request, response and csr ports and is bound to the top level.
// ----------------------------------------------------------------------------
module lfr_check import lfr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_valid,
   input logic csr_ready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word after reset");

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("response word without matching request");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write held off");

endmodule

bind limited_face_reconstruction_core lfr_check u_lfr_check (.*);

FILE: tb/limited_face_reconstruction_core_tb.sv
// ----------------------------------------------------------------------------
// limited_face_reconstruction_core_tb: face reconstruction self-checking bench
// Drives stencils of five cell values through every method and a range of
// flatness thresholds, predicts both faces in the bench and compares every
// result word in order against the predicted faces.
// ----------------------------------------------------------------------------
module limited_face_reconstruction_core_tb;
   import lfr_pkg::*;

   typedef logic signed [VALUE_WIDTH-1:0] value_t;

   class face_scoreboard;
      typedef struct {
         value_t left_face;
         value_t right_face;
      } faces_t;

      logic [METHOD_W-1:0] method_sel;
      logic [THRESH_W-1:0] flat_thr;
      faces_t              pending_faces[$];
      int                  errors;

      function new();
         method_sel = METHOD_MC;
         flat_thr   = '0;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_METHOD) begin
            method_sel = data[METHOD_W-1:0];
         end else if (idx == CSR_FLAT) begin
            flat_thr = data[THRESH_W-1:0];
         end
      endfunction

      static function int sgn(longint x);
         return (x > 0) - (x < 0);
      endfunction

      static function longint unsigned mag(longint x);
         return x < 0 ? -x : x;
      endfunction

      static function longint signed_of(int s, longint unsigned u);
         return s < 0 ? -longint'(u) : longint'(u);
      endfunction

      static function longint umin(longint unsigned a, longint unsigned b);
         return a < b ? a : b;
      endfunction

      // round to nearest, ties away from zero
      static function longint round_div(longint n, longint unsigned d);
         return signed_of(sgn(n), (mag(n) + d / 2) / d);
      endfunction

      static function longint scale_mag(longint x, longint unsigned num,
                                        longint unsigned den);
         logic [127:0] prod;
         logic [127:0] q;
         prod = 128'(mag(x)) * 128'(num);
         q    = (2 * prod + 128'(den)) / (2 * 128'(den));
         return signed_of(sgn(x), q[63:0]);
      endfunction

      static function longint minmod2(longint a, longint b);
         if (sgn(a) * sgn(b) <= 0) return 0;
         return mag(a) < mag(b) ? a : b;
      endfunction

      static function longint minmod3(longint a, longint b, longint c);
         if (sgn(a) * sgn(b) <= 0 || sgn(a) * sgn(c) <= 0) return 0;
         return signed_of(sgn(a), umin(mag(a), umin(mag(b), mag(c))));
      endfunction

      static function longint limit_face(longint f, longint oa, longint a,
                                         longint b, longint ob);
         longint d2, d2l, d2r;
         longint unsigned lim4;
         lim4 = 0;
         if (sgn(a - f) * sgn(b - f) <= 0) return f;
         d2  = 3 * (a - 2 * f + b);
         d2l = oa - 2 * a + b;
         d2r = a - 2 * b + ob;
         if (sgn(d2) * sgn(d2l) > 0 && sgn(d2) * sgn(d2r) > 0)
            lim4 = umin(5 * mag(d2l), umin(5 * mag(d2r), 4 * mag(d2)));
         return round_div(12 * (a + b) - signed_of(sgn(d2), lim4), 24);
      endfunction

      function void ppm_faces(longint mm, longint m, longint c, longint p,
                              longint pp, output longint lf, output longint rf);
         longint d2, d2c, d2l, d2r;
         longint unsigned lim4;
         int s;
         rf = round_div(7 * (c + p) - (m + pp), 12);
         lf = round_div(7 * (c + m) - (mm + p), 12);
         rf = limit_face(rf, m, c, p, pp);
         lf = limit_face(lf, mm, m, c, p);
         if (sgn(rf - c) * sgn(c - lf) <= 0 || sgn(m - c) * sgn(c - p) <= 0) begin
            d2  = 6 * (lf - 2 * c + rf);
            d2c = m - 2 * c + p;
            d2l = mm - 2 * m + c;
            d2r = c - 2 * p + pp;
            s   = sgn(d2);
            if (mag(d2) < longint'(flat_thr) ||
                !(s * sgn(d2c) > 0 && s * sgn(d2l) > 0 && s * sgn(d2r) > 0)) begin
               rf = c;
               lf = c;
            end else begin
               lim4 = umin(umin(5 * mag(d2l), 5 * mag(d2r)),
                           umin(5 * mag(d2c), 4 * mag(d2)));
               rf = c + scale_mag(rf - c, lim4, 4 * mag(d2));
               lf = c + scale_mag(lf - c, lim4, 4 * mag(d2));
            end
         end
      endfunction

      static function value_t saturate(longint x);
         longint hi, lo;
         hi = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
         lo = -hi - 1;
         return value_t'(x > hi ? hi : (x < lo ? lo : x));
      endfunction

      // predict the faces of one accepted stencil
      function void note_stencil(value_t vmm, value_t vm, value_t vc, value_t vp,
                                 value_t vpp);
         longint mm, m, c, p, pp, lf, rf, h;
         faces_t f;
         mm = vmm; m = vm; c = vc; p = vp; pp = vpp;
         lf = c;
         rf = c;
         case (method_sel)
            METHOD_FROMM: begin
               h = round_div(p - m, 4);
               lf = c - h; rf = c + h;
            end
            METHOD_MINMOD: begin
               h = round_div(minmod2(p - c, c - m), 2);
               lf = c - h; rf = c + h;
            end
            METHOD_MC: begin
               h = round_div(minmod3(4 * (p - c), p - m, 4 * (c - m)), 4);
               lf = c - h; rf = c + h;
            end
            METHOD_PPM: ppm_faces(mm, m, c, p, pp, lf, rf);
            default: ;
         endcase
         f.left_face  = saturate(lf);
         f.right_face = saturate(rf);
         pending_faces.push_back(f);
      endfunction

      function void check_faces(value_t got_l, value_t got_r);
         faces_t f;
         if (pending_faces.size() == 0) begin
            $display("%0t: unexpected result word left %0d right %0d", $time, got_l, got_r);
            errors++;
            return;
         end
         f = pending_faces.pop_front();
         if (got_l !== f.left_face) begin
            $display("%0t: left_face mismatch expected %0d actual %0d",
                     $time, f.left_face, got_l);
            errors++;
         end
         if (got_r !== f.right_face) begin
            $display("%0t: right_face mismatch expected %0d actual %0d",
                     $time, f.right_face, got_r);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   value_t req_far_left_value = '0;
   value_t req_left_value = '0;
   value_t req_centre_value = '0;
   value_t req_right_value = '0;
   value_t req_far_right_value = '0;
   logic rsp_valid;
   value_t rsp_left_face;
   value_t rsp_right_face;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   face_scoreboard faces_sb = new();
   int idle_cycles = 0;

   always #4 clock = ~clock;

   limited_face_reconstruction_core dut (.*);

   // monitor: note accepted stencils, writes and result words
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            faces_sb.note_stencil(req_far_left_value, req_left_value, req_centre_value,
                                  req_right_value, req_far_right_value);
         end
         if (csr_valid && csr_ready) faces_sb.write_reg(csr_index, csr_data);
         if (rsp_valid) faces_sb.check_faces(rsp_left_face, rsp_right_face);
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic idle_gap();
      int pick;
      int gap;
      pick = $urandom_range(0, 9);
      gap = pick < 6 ? 0 : (pick < 9 ? $urandom_range(1, 3) : $urandom_range(10, 80));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_stencil(value_t mm, value_t m, value_t c, value_t p, value_t pp);
      req_far_left_value  <= mm;
      req_left_value      <= m;
      req_centre_value    <= c;
      req_right_value     <= p;
      req_far_right_value <= pp;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      idle_gap();
   endtask

   // hold until every result word is back, then let the pipeline empty
   task automatic drain();
      start <= 1'b0;
      while (faces_sb.pending_faces.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // write only with the pipeline empty
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain();
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_stencil();
      value_t v[5];
      longint a, b, q, x;
      int kind;
      kind = $urandom_range(0, 9);
      a = $signed($urandom()) >>> $urandom_range(0, 24);
      b = $signed($urandom()) >>> $urandom_range(4, 28);
      q = $signed($urandom()) >>> $urandom_range(6, 30);
      for (int i = 0; i < 5; i++) begin
         case (kind)
            0, 1: v[i] = $urandom();
            2: begin
               x = a + $signed($urandom_range(0, 2000)) - 1000;
               v[i] = value_t'(x);
            end
            3: case ($urandom_range(0, 4))
                  0: v[i] = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                  1: v[i] = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                  2: v[i] = '0;
                  3: v[i] = '1;
                  default: v[i] = $urandom();
               endcase
            default: begin
               // smooth profile: a + b*(i-2) + q*(i-2)*(i-2), small jitter
               x = a + b * (i - 2) + q * (i - 2) * (i - 2) + $urandom_range(0, 3);
               v[i] = VALUE_WIDTH'(x);
               if (x > 64'sh7FFFFFFF || x < -64'sh80000000) v[i] = $urandom();
            end
         endcase
      end
      send_stencil(v[0], v[1], v[2], v[3], v[4]);
   endtask

   initial begin
      logic [METHOD_W-1:0] mode;
      logic [THRESH_W-1:0] thr;
      value_t vmax, vmin;
      vmax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      vmin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset mode first, then PPM special cases and the other modes
      send_stencil(0, 65536, 131072, 262144, 327680);
      send_stencil(vmin, vmin, vmax, vmax, vmax);
      write_csr(CSR_METHOD, CSR_DATA_W'(METHOD_PPM));
      send_stencil(0, 65536, 131072, 196608, 262144);
      send_stencil(0, 65536, 262144, 131072, 0);
      send_stencil(0, 65536, 131072, 65536, 0);
      send_stencil(7, 7, 7, 7, 7);
      send_stencil(vmax, vmax, vmin, vmax, vmax);
      send_stencil(vmin, vmax, vmin, vmax, vmin);
      send_stencil(-65536, 0, 65536, 0, -65536);
      send_stencil(0, 1000, 1500, 1000, 0);
      send_stencil(0, 0, 1, 0, 0);
      drain();
      write_csr(CSR_FLAT, 16'hFFFF);
      send_stencil(0, 1000, 1500, 1000, 0);
      send_stencil(-65536, 0, 65536, 0, -65536);
      send_stencil(0, 30000, 40000, 30000, 0);
      drain();
      write_csr(2'd2, 16'hFFFF);
      write_csr(2'd3, 16'h0000);
      write_csr(CSR_METHOD, CSR_DATA_W'(METHOD_FROMM));
      send_stencil(vmin, vmin, vmax, vmax, vmax);
      send_stencil(vmax, vmax, vmin, vmin, vmin);
      write_csr(CSR_METHOD, CSR_DATA_W'(METHOD_MINMOD));
      send_stencil(vmin, vmin, 0, vmax, vmax);
      send_stencil(0, 0, 65536, 131072, 0);
      write_csr(CSR_METHOD, CSR_DATA_W'(METHOD_UPWIND));
      send_stencil(1, 2, vmin, 4, 5);
      write_csr(CSR_METHOD, CSR_DATA_W'(3'd7));
      send_stencil(1, 2, 3, 4, 5);
      drain();

      // random phases across every mode code and several thresholds
      for (int ph = 0; ph < 16; ph++) begin
         mode = ph < 8 ? METHOD_W'(ph) : ($urandom_range(0, 1) ? METHOD_PPM
                                          : METHOD_W'($urandom_range(0, 7)));
         case (ph % 4)
            0: thr = '0;
            1: thr = '1;
            2: thr = $urandom_range(1, 255);
            default: thr = $urandom();
         endcase
         write_csr(CSR_METHOD, CSR_DATA_W'(mode));
         write_csr(CSR_FLAT, thr);
         repeat (ph < 8 ? 40 : 85) random_stencil();
         drain();
      end

      if (faces_sb.errors == 0 && faces_sb.pending_faces.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
